// File: sv/line_column_locator_macros.svh
// ----------------------------------------------------------------------------
// line_column_locator_macros.svh
// Assertion macros shared by the line and column locator.
// ----------------------------------------------------------------------------
`ifndef LINE_COLUMN_LOCATOR_MACROS_SVH
`define LINE_COLUMN_LOCATOR_MACROS_SVH

// Checks a consequence in the same cycle as its condition.
`define LCL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its condition.
`define LCL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// Types and constants of the line and column locator.
// ----------------------------------------------------------------------------
package lcl_pkg;

   localparam int MAX_LINES   = 1024;
   localparam int OFFSET_BITS = 20;
   localparam int IDX_BITS    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CNT_BITS    = $clog2(MAX_LINES + 1);
   localparam int QUERY_BITS  = 20;
   localparam int LINE_BITS   = 11;
   localparam int COL_BITS    = 21;
   localparam int CMP_BITS    = (OFFSET_BITS > QUERY_BITS) ? OFFSET_BITS : QUERY_BITS;

   localparam logic [7:0]             NEWLINE_BYTE = 8'h0A;
   localparam logic [OFFSET_BITS-1:0] POS_TOP      = '1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } lcl_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } lcl_state_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [7:0]            text_byte;
      logic [QUERY_BITS-1:0] query_offset;
   } req_type;

   typedef struct packed {
      logic [LINE_BITS-1:0] line_number;
      logic [COL_BITS-1:0]  column_number;
      logic                 overflow_seen;
   } rsp_type;

   typedef struct packed {
      logic                   en;
      logic [IDX_BITS-1:0]    addr;
      logic [OFFSET_BITS-1:0] data;
   } lcl_ram_wr_type;

   typedef struct packed {
      logic                searching;
      logic [CNT_BITS-1:0] line_count;
   } lcl_status_type;

endpackage

// File: sv/lcl_line_ram.sv
// ----------------------------------------------------------------------------
// lcl_line_ram
// Line start memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcl_line_ram (
   input  logic                             clock,
   input  lcl_pkg::lcl_ram_wr_type          wr,
   input  logic [lcl_pkg::IDX_BITS-1:0]     rd_addr,
   output logic [lcl_pkg::OFFSET_BITS-1:0]  rd_data
);
   import lcl_pkg::*;

   logic [OFFSET_BITS-1:0] line_start_mem [MAX_LINES];
   logic [OFFSET_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         line_start_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= line_start_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lcl_ctrl.sv
// ----------------------------------------------------------------------------
// lcl_ctrl
// Sequencer: text counters, table appends and the binary search of a query.
// ----------------------------------------------------------------------------
module lcl_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lcl_pkg::req_type                 req_data,
   output lcl_pkg::lcl_ram_wr_type          ram_wr,
   output logic [lcl_pkg::IDX_BITS-1:0]     ram_rd_addr,
   input  logic [lcl_pkg::OFFSET_BITS-1:0]  ram_rd_data,
   output logic                             res_valid,
   input  logic                             res_ready,
   output lcl_pkg::rsp_type                 res_data,
   output lcl_pkg::lcl_status_type          status
);
   import lcl_pkg::*;

   lcl_state_type          state_ff, state_in;
   logic [CNT_BITS-1:0]    line_count_ff, line_count_in;
   logic [OFFSET_BITS-1:0] byte_pos_ff, byte_pos_in;
   logic                   overflow_ff, overflow_in;
   logic [CNT_BITS-1:0]    lo_ff, lo_in;
   logic [CNT_BITS-1:0]    hi_ff, hi_in;
   logic [IDX_BITS-1:0]    mid_ff, mid_in;
   logic [IDX_BITS-1:0]    best_ff, best_in;
   logic [OFFSET_BITS-1:0] best_start_ff, best_start_in;
   logic [QUERY_BITS-1:0]  offset_ff, offset_in;

   logic [OFFSET_BITS-1:0] start_val;
   logic                   take;
   logic [CNT_BITS-1:0]    lo_next;
   logic [CNT_BITS-1:0]    hi_next;
   logic [CNT_BITS-1:0]    mid_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         line_count_ff <= CNT_BITS'(1);
         byte_pos_ff   <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         line_count_ff <= line_count_in;
         byte_pos_ff   <= byte_pos_in;
         overflow_ff   <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      best_ff       <= best_in;
      best_start_ff <= best_start_in;
      offset_ff     <= offset_in;
   end

   // Entry 0 is always offset zero and is never written.
   assign start_val = (mid_ff == '0) ? '0 : ram_rd_data;
   assign take      = CMP_BITS'(start_val) <= CMP_BITS'(offset_ff);
   assign lo_next   = take ? (CNT_BITS'(mid_ff) + 1'b1) : lo_ff;
   assign hi_next   = take ? hi_ff : CNT_BITS'(mid_ff);
   assign mid_next  = lo_next + ((hi_next - lo_next) >> 1);

   always_comb begin
      state_in      = state_ff;
      line_count_in = line_count_ff;
      byte_pos_in   = byte_pos_ff;
      overflow_in   = overflow_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      best_in       = best_ff;
      best_start_in = best_start_ff;
      offset_in     = offset_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      ram_wr        = '0;
      ram_rd_addr   = IDX_BITS'(line_count_ff >> 1);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_data.op)
                  OP_CLEAR: begin
                     line_count_in = CNT_BITS'(1);
                     byte_pos_in   = '0;
                     overflow_in   = 1'b0;
                  end
                  OP_APPEND: begin
                     if (byte_pos_ff == POS_TOP) begin
                        overflow_in = 1'b1;
                     end else begin
                        if (req_data.text_byte == NEWLINE_BYTE) begin
                           if (line_count_ff < CNT_BITS'(MAX_LINES)) begin
                              ram_wr.en     = 1'b1;
                              ram_wr.addr   = IDX_BITS'(line_count_ff);
                              ram_wr.data   = byte_pos_ff + 1'b1;
                              line_count_in = line_count_ff + 1'b1;
                           end else begin
                              overflow_in = 1'b1;
                           end
                        end
                        byte_pos_in = byte_pos_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     // The read of the first midpoint is issued in this cycle.
                     offset_in     = req_data.query_offset;
                     lo_in         = '0;
                     hi_in         = line_count_ff;
                     mid_in        = IDX_BITS'(line_count_ff >> 1);
                     best_in       = '0;
                     best_start_in = '0;
                     state_in      = ST_SEARCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // One step per cycle: compare the entry just read, then read the next midpoint.
            ram_rd_addr = IDX_BITS'(mid_next);
            lo_in       = lo_next;
            hi_in       = hi_next;
            mid_in      = IDX_BITS'(mid_next);
            if (take) begin
               best_in       = mid_ff;
               best_start_in = start_val;
            end
            if (!(lo_next < hi_next)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_data.line_number   = LINE_BITS'(CNT_BITS'(best_ff) + 1'b1);
   assign res_data.column_number = COL_BITS'(offset_ff) - COL_BITS'(best_start_ff) + 1'b1;
   assign res_data.overflow_seen = overflow_ff;

   assign status.searching  = (state_ff == ST_SEARCH);
   assign status.line_count = line_count_ff;

endmodule

// File: sv/line_column_locator.sv
// ----------------------------------------------------------------------------
// line_column_locator
// Line start table with binary-search lookup of line and column numbers.
// ----------------------------------------------------------------------------
// Clear and append requests are done in the idle state. A query is answered
// by a binary search over the line start memory, one step per cycle, since each
// step compares the entry from the registered memory read and issues the next
// read in the same cycle: a text with N lines takes up to ceil(log2(N+1))
// steps (11 with a full 1024-line table), plus the idle state that accepts the
// query and the done state that hands the answer to the output register. The
// output register lets the next request in while an answer waits. The memory
// needs no clearing after reset; entry 0 reads as offset zero by construction.
`include "line_column_locator_macros.svh"

module line_column_locator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lcl_pkg::rsp_type rsp_data
);
   import lcl_pkg::*;

   lcl_ram_wr_type         ram_wr;
   logic [IDX_BITS-1:0]    ram_rd_addr;
   logic [OFFSET_BITS-1:0] ram_rd_data;
   logic                   res_valid;
   logic                   res_ready;
   rsp_type                res_data;
   lcl_status_type         status;

   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   lcl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .ram_wr      (ram_wr),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .status      (status)
   );

   lcl_line_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `LCL_ASSERT_SAME(a_count_range, 1'b1,
      (status.line_count != '0) && (status.line_count <= CNT_BITS'(MAX_LINES)),
      "line count out of range")
   `LCL_ASSERT_SAME(a_no_req_while_search, status.searching, !req_ready,
      "request taken during a search")
   `LCL_ASSERT_NEXT(a_query_starts_search,
      req_valid && req_ready && (req_data.op == OP_QUERY), status.searching,
      "query did not start a search")
   `LCL_ASSERT_NEXT(a_count_only_on_request, !(req_valid && req_ready),
      $stable(status.line_count), "line count changed without a request")

endmodule
